// ===== rtl/core/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, letter codes and key-square lookup helpers for the Playfair
// digraph cipher core.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int SIDE    = 5;
  localparam int CELLS   = SIDE * SIDE;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef logic [4:0] letter_t;
  typedef logic [2:0] coord_t;
  typedef logic [CELLS-1:0][4:0] square_t;

  localparam letter_t CODE_I = 5'd8;
  localparam letter_t CODE_J = 5'd9;
  localparam letter_t CODE_X = 5'd23;

  localparam coord_t COORD_MAX = coord_t'(SIDE - 1);

  typedef enum logic [2:0] {
    CFG_SQUARE_FIRST  = 3'd0,
    CFG_SQUARE_MIDDLE = 3'd1,
    CFG_SQUARE_LAST   = 3'd2,
    CFG_DECRYPT_MODE  = 3'd3
  } cfg_index_t;

  // One digraph request; dbl emits (a, X) twice, the first not ending the run.
  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    dbl;
  } req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    letter_t first_out;
    letter_t second_out;
    logic    run_end;
  } res_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  // First matching cell in row-major order; no match gives row 0, column 0.
  function automatic pos_t locate(square_t sq, letter_t code);
    pos_t p;
    p.row = '0;
    p.col = '0;
    for (int k = CELLS - 1; k >= 0; k--) begin
      if (sq[k] == code) begin
        p.row = coord_t'(k / SIDE);
        p.col = coord_t'(k % SIDE);
      end
    end
    return p;
  endfunction

  function automatic coord_t step_coord(coord_t c, logic back);
    coord_t r;
    if (back) begin
      r = (c == '0) ? COORD_MAX : coord_t'(c - 3'd1);
    end else begin
      r = (c == COORD_MAX) ? '0 : coord_t'(c + 3'd1);
    end
    return r;
  endfunction

  function automatic letter_t cell_of(square_t sq, coord_t row, coord_t col);
    logic [4:0] idx;
    idx = 5'({row, 2'b00}) + 5'(row) + 5'(col);
    return sq[idx];
  endfunction

endpackage

// ===== rtl/core/pfc_front.sv =====
// ----------------------------------------------------------------------------
// pfc_front
// Letter pairing: folds J to I, holds the odd letter and turns each accepted
// letter into at most one digraph request for the back end.
// ----------------------------------------------------------------------------
module pfc_front
  import pfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_push,
  input  letter_t in_letter,
  input  logic    in_message_end,
  input  logic    decrypt,
  input  q_stat_t q_stat,
  output logic    in_full,
  output logic    req_push,
  output req_t    req
);

  letter_t held_letter_r, held_letter_nxt;
  logic    held_valid_r, held_valid_nxt;
  letter_t letter_f;
  logic    take;

  assign in_full  = q_stat.full;
  assign take     = in_push && !q_stat.full;
  assign letter_f = (in_letter == CODE_J) ? CODE_I : in_letter;

  always_comb begin
    held_letter_nxt = held_letter_r;
    held_valid_nxt  = held_valid_r;
    req_push        = 1'b0;
    req.a           = letter_f;
    req.b           = CODE_X;
    req.dbl         = 1'b0;
    if (take) begin
      if (!held_valid_r) begin
        if (in_message_end) begin
          req_push = 1'b1;
        end else begin
          held_letter_nxt = letter_f;
          held_valid_nxt  = 1'b1;
        end
      end else if (letter_f != held_letter_r || decrypt) begin
        req_push        = 1'b1;
        req.a           = held_letter_r;
        req.b           = letter_f;
        held_letter_nxt = '0;
        held_valid_nxt  = 1'b0;
      end else begin
        // doubled letter: split with filler, keep the second letter held unless it ends the message
        req_push = 1'b1;
        req.a    = held_letter_r;
        if (in_message_end) begin
          req.dbl         = 1'b1;
          held_letter_nxt = '0;
          held_valid_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_letter_r <= '0;
      held_valid_r  <= 1'b0;
    end else begin
      held_letter_r <= held_letter_nxt;
      held_valid_r  <= held_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/pfc_queue.sv =====
// ----------------------------------------------------------------------------
// pfc_queue
// Short request queue between the pairing front end and the substitution
// back end.
// ----------------------------------------------------------------------------
module pfc_queue
  import pfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  req_t    wr_req,
  input  logic    pop,
  output req_t    head,
  output q_stat_t stat
);

  req_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/pfc_back.sv =====
// ----------------------------------------------------------------------------
// pfc_back
// Digraph substitution through the key square, one result per cycle while a
// request waits and the two-entry result queue has room, into that queue.
// ----------------------------------------------------------------------------
module pfc_back
  import pfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  req_t    head,
  input  q_stat_t q_stat,
  output logic    q_pop,
  input  square_t square,
  input  logic    decrypt,
  input  logic    out_pop,
  output logic    out_empty,
  output letter_t out_first_out,
  output letter_t out_second_out,
  output logic    out_run_end
);

  res_t       rq [2];
  logic       rq_wr_r, rq_rd_r;
  logic [1:0] rq_cnt_r, rq_cnt_nxt;
  logic       phase_r, phase_nxt;
  logic       fire, rd_fire;
  pos_t       p1, p2;
  res_t       res;

  assign out_empty = (rq_cnt_r == 2'd0);
  assign rd_fire   = out_pop && !out_empty;
  assign fire      = !q_stat.empty && (rq_cnt_r != 2'd2);

  assign out_first_out  = rq[rq_rd_r].first_out;
  assign out_second_out = rq[rq_rd_r].second_out;
  assign out_run_end    = rq[rq_rd_r].run_end;

  always_comb begin
    p1 = locate(square, head.a);
    p2 = locate(square, head.b);
    if (p1.row == p2.row) begin
      res.first_out  = cell_of(square, p1.row, step_coord(p1.col, decrypt));
      res.second_out = cell_of(square, p2.row, step_coord(p2.col, decrypt));
    end else if (p1.col == p2.col) begin
      res.first_out  = cell_of(square, step_coord(p1.row, decrypt), p1.col);
      res.second_out = cell_of(square, step_coord(p2.row, decrypt), p2.col);
    end else begin
      res.first_out  = cell_of(square, p1.row, p2.col);
      res.second_out = cell_of(square, p2.row, p1.col);
    end
    res.run_end = !head.dbl || phase_r;
  end

  // a doubled request stays at the head for its second beat
  always_comb begin
    phase_nxt = phase_r;
    q_pop     = 1'b0;
    if (fire) begin
      if (head.dbl && !phase_r) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        q_pop     = 1'b1;
      end
    end
  end

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (fire && !rd_fire) begin
      rq_cnt_nxt = rq_cnt_r + 2'd1;
    end else if (rd_fire && !fire) begin
      rq_cnt_nxt = rq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rq[rq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= 1'b0;
      rq_rd_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
      phase_r  <= 1'b0;
    end else begin
      if (fire) begin
        rq_wr_r <= !rq_wr_r;
      end
      if (rd_fire) begin
        rq_rd_r <= !rq_rd_r;
      end
      rq_cnt_r <= rq_cnt_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

// ===== rtl/core/playfair_digraph_cipher_core.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core
// Playfair digraph cipher over a 5x5 key square held in registers.
// Input channel: one letter (A=0..Z=25) per beat with in_push / in_full;
// message_end marks the final letter. Letters are paired by the front end,
// which queues digraph requests (four deep) for the substitution back end.
// Result channel: out_empty / out_pop; each beat carries one substituted
// digraph, run_end set on the last digraph caused by a letter.
// Throughput: one letter per cycle while in_full is low; a letter that yields
// two digraphs (doubled letter at message end) occupies the back end for both,
// as the back end writes one digraph per cycle, when its two-entry result
// queue has room. A digraph passes through the request queue and then the
// result queue before it shows on the result ports, where it can be popped.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects
// square_first, square_middle, square_last or decrypt_mode; other indexes
// are dropped. Write only while the block is idle.
// Reset clears the key square, the mode, the held letter and both queues.
// A stalled receiver fills the result queue, then the request queue, and
// in_full rises; nothing is lost.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_core
  import pfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [4:0]  in_letter,
  input  logic        in_message_end,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_first_out,
  output logic [4:0]  out_second_out,
  output logic        out_run_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [49:0] cfg_data
);

  logic [49:0] square_first_r;
  logic [49:0] square_middle_r;
  logic [24:0] square_last_r;
  logic        decrypt_mode_r;
  square_t     square;

  req_t    req, head;
  logic    req_push, q_pop;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;
  assign square    = {square_last_r, square_middle_r, square_first_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_first_r  <= '0;
      square_middle_r <= '0;
      square_last_r   <= '0;
      decrypt_mode_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SQUARE_FIRST:  square_first_r  <= cfg_data;
        CFG_SQUARE_MIDDLE: square_middle_r <= cfg_data;
        CFG_SQUARE_LAST:   square_last_r   <= cfg_data[24:0];
        CFG_DECRYPT_MODE:  decrypt_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pfc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_letter      (in_letter),
    .in_message_end (in_message_end),
    .decrypt        (decrypt_mode_r),
    .q_stat         (q_stat),
    .in_full        (in_full),
    .req_push       (req_push),
    .req            (req)
  );

  pfc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (req_push),
    .wr_req (req),
    .pop    (q_pop),
    .head   (head),
    .stat   (q_stat)
  );

  pfc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .square         (square),
    .decrypt        (decrypt_mode_r),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_first_out  (out_first_out),
    .out_second_out (out_second_out),
    .out_run_end    (out_run_end)
  );

endmodule

// ===== dv/playfair_digraph_cipher_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core_tb
// Self-checking bench for the Playfair digraph core. A letter stream is fed
// through the push/full port and every popped digraph is checked against an
// in-bench predictor of the pairing, filler and key-square substitution
// rules. Directed letters cover row, column and corner pairs, doubled
// letters, padding, J folding, letters off the square and a mode change with
// a letter held. Random messages then run over many key squares, valid and
// corrupt, in both modes, with random stalls on both sides.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_core_tb;
  import pfc_pkg::*;

  localparam int      SETTLE_CYCLES = 8;
  localparam int      QUIET_LIMIT   = 4000;
  localparam int      RANDOM_ITEMS  = 450;
  localparam int      PHASE_ITEMS   = 60;
  localparam int      MAX_PRINTS    = 40;
  localparam letter_t LAST_LETTER   = 5'd25;

  typedef struct packed {
    letter_t letter;
    logic    fin;
  } letter_beat_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_push        = 1'b0;
  logic [4:0]  in_letter      = '0;
  logic        in_message_end = 1'b0;
  logic        out_pop        = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic [2:0]  cfg_index      = '0;
  logic [49:0] cfg_data       = '0;
  logic        in_full;
  logic        out_empty;
  logic [4:0]  out_first_out;
  logic [4:0]  out_second_out;
  logic        out_run_end;
  logic        cfg_ready;

  playfair_digraph_cipher_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_letter      (in_letter),
    .in_message_end (in_message_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_first_out  (out_first_out),
    .out_second_out (out_second_out),
    .out_run_end    (out_run_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: key square, mode and the letter waiting for a partner.
  square_t      key_sq     = '0;
  logic         decrypt_on = 1'b0;
  letter_t      held_ltr   = '0;
  logic         held_ok    = 1'b0;

  letter_beat_t letter_queue[$];
  res_t         digraph_queue[$];

  logic in_took  = 1'b0;
  logic out_took = 1'b0;
  int   send_gap = 0;
  int   send_calm = 0;
  int   pop_hold = 0;
  int   pop_calm = 0;
  int   quiet_cycles = 0;
  int   errors = 0;
  int   letters_in = 0;
  int   digraphs_seen = 0;
  int   double_hits = 0;
  int   cfg_writes = 0;
  int   setups = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic int find_cell(letter_t code);
    for (int k = 0; k < CELLS; k++) begin
      if (key_sq[k] == code) return k;
    end
    return 0;
  endfunction

  function automatic res_t cipher_pair(letter_t a, letter_t b, logic last);
    int   pa, pb, r1, c1, r2, c2, step;
    res_t d;
    pa   = find_cell(a);
    pb   = find_cell(b);
    r1   = pa / SIDE;
    c1   = pa % SIDE;
    r2   = pb / SIDE;
    c2   = pb % SIDE;
    step = decrypt_on ? SIDE - 1 : 1;
    if (r1 == r2) begin
      d.first_out  = key_sq[r1 * SIDE + (c1 + step) % SIDE];
      d.second_out = key_sq[r2 * SIDE + (c2 + step) % SIDE];
    end else if (c1 == c2) begin
      d.first_out  = key_sq[((r1 + step) % SIDE) * SIDE + c1];
      d.second_out = key_sq[((r2 + step) % SIDE) * SIDE + c2];
    end else begin
      d.first_out  = key_sq[r1 * SIDE + c2];
      d.second_out = key_sq[r2 * SIDE + c1];
    end
    d.run_end = last;
    return d;
  endfunction

  task automatic absorb_letter(input letter_t raw, input logic fin);
    letter_t ltr;
    ltr = (raw == CODE_J) ? CODE_I : raw;
    letters_in++;
    if (!held_ok) begin
      if (fin) begin
        digraph_queue.push_back(cipher_pair(ltr, CODE_X, 1'b1));
      end else begin
        held_ltr = ltr;
        held_ok  = 1'b1;
      end
    end else if (ltr != held_ltr || decrypt_on) begin
      digraph_queue.push_back(cipher_pair(held_ltr, ltr, 1'b1));
      held_ok  = 1'b0;
      held_ltr = '0;
    end else if (fin) begin
      // Doubled letter closing the message: two filler digraphs.
      digraph_queue.push_back(cipher_pair(held_ltr, CODE_X, 1'b0));
      digraph_queue.push_back(cipher_pair(ltr, CODE_X, 1'b1));
      held_ok  = 1'b0;
      held_ltr = '0;
      double_hits++;
    end else begin
      // Split the double with X; the repeat starts the next pair.
      digraph_queue.push_back(cipher_pair(held_ltr, CODE_X, 1'b1));
    end
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(16, 48);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Letter driver.
  always @(negedge clk) begin
    letter_beat_t beat;
    logic         push_next;
    push_next = in_push;
    if (in_push && !in_took) begin
      push_next = 1'b1;  // hold the beat until it is taken
    end else if (send_gap > 0) begin
      push_next = 1'b0;
      send_gap--;
      in_letter      <= 5'($urandom);
      in_message_end <= 1'($urandom);
    end else if (letter_queue.size() != 0) begin
      beat = letter_queue.pop_front();
      push_next = 1'b1;
      in_letter      <= beat.letter;
      in_message_end <= beat.fin;
      send_gap = pick_gap(send_calm);
    end else begin
      push_next = 1'b0;
      in_letter      <= 5'($urandom);
      in_message_end <= 1'($urandom);
    end
    in_push <= push_next;
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    if (out_took) pop_hold = pick_gap(pop_calm);
    if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold--;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Monitor: register writes, result checks, letter prediction.
  always @(posedge clk) begin
    res_t seen;
    res_t want;
    logic cfg_took;
    in_took  = rst_n && in_push && !in_full;
    out_took = rst_n && out_pop && !out_empty;
    cfg_took = rst_n && cfg_valid && cfg_ready;
    if (cfg_took) begin
      case (cfg_index)
        CFG_SQUARE_FIRST:  key_sq[9:0]   = cfg_data;
        CFG_SQUARE_MIDDLE: key_sq[19:10] = cfg_data;
        CFG_SQUARE_LAST:   key_sq[24:20] = cfg_data[24:0];
        CFG_DECRYPT_MODE:  decrypt_on    = cfg_data[0];
        default: ;  // drop writes to unused indexes
      endcase
      cfg_writes++;
    end
    if (out_took) begin
      seen.first_out  = out_first_out;
      seen.second_out = out_second_out;
      seen.run_end    = out_run_end;
      digraphs_seen++;
      if (digraph_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected digraph %0d,%0d run_end %0b",
                                  seen.first_out, seen.second_out, seen.run_end));
      end else begin
        want = digraph_queue.pop_front();
        if (seen.first_out !== want.first_out)
          report_mismatch($sformatf("digraph %0d first_out got %0d want %0d",
                                    digraphs_seen, seen.first_out, want.first_out));
        if (seen.second_out !== want.second_out)
          report_mismatch($sformatf("digraph %0d second_out got %0d want %0d",
                                    digraphs_seen, seen.second_out, want.second_out));
        if (seen.run_end !== want.run_end)
          report_mismatch($sformatf("digraph %0d run_end got %0b want %0b",
                                    digraphs_seen, seen.run_end, want.run_end));
      end
    end
    if (in_took) absorb_letter(in_letter, in_message_end);
    if (in_took || out_took || cfg_took) quiet_cycles = 0;
    else if (rst_n) quiet_cycles++;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [49:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
  endtask

  task automatic close_cfg();
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 50'({$urandom, $urandom});
  endtask

  task automatic load_setup(input square_t sq, input logic mode, input logic [48:0] pad);
    logic [2:0] spare;
    spare = 3'($urandom_range(int'(CFG_DECRYPT_MODE) + 1, (1 << $bits(cfg_index)) - 1));
    write_reg(CFG_SQUARE_FIRST, sq[9:0]);
    write_reg(CFG_SQUARE_MIDDLE, sq[19:10]);
    write_reg(CFG_SQUARE_LAST, {pad[24:0], sq[24:20]});
    write_reg(CFG_DECRYPT_MODE, {pad, mode});
    write_reg(spare, 50'({$urandom, $urandom}));
    close_cfg();
    setups++;
  endtask

  // Wait out every expected digraph, then the pipeline's own latency.
  task automatic drain_and_settle();
    @(posedge clk);
    while (letter_queue.size() != 0 || in_push || digraph_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic square_t square_from(string key);
    square_t sq;
    for (int k = 0; k < CELLS; k++) sq[k] = letter_t'(key[k] - "A");
    return sq;
  endfunction

  function automatic square_t shuffled_square();
    letter_t pool[CELLS];
    letter_t tmp;
    square_t sq;
    int      n, j;
    n = 0;
    for (int c = 0; c <= LAST_LETTER; c++) begin
      if (letter_t'(c) != CODE_J) begin
        pool[n] = letter_t'(c);
        n++;
      end
    end
    for (int k = CELLS - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = pool[k];
      pool[k] = pool[j];
      pool[j] = tmp;
    end
    for (int k = 0; k < CELLS; k++) sq[k] = pool[k];
    return sq;
  endfunction

  // Duplicates, J cells and codes past Z all show up here.
  function automatic square_t corrupt_square();
    square_t sq;
    for (int k = 0; k < CELLS; k++) sq[k] = letter_t'($urandom);
    return sq;
  endfunction

  task automatic queue_char(input byte ch, input logic fin);
    letter_queue.push_back('{letter_t'(ch - "A"), fin});
  endtask

  task automatic queue_message(input int len, input logic noisy, inout int count);
    letter_t prev;
    letter_t ltr;
    logic    fin;
    int      r;
    prev = letter_t'($urandom_range(0, LAST_LETTER));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (i > 0 && r < 25) ltr = prev;
      else if (r < 35) ltr = CODE_X;
      else if (r < 40) ltr = CODE_J;
      else if (noisy && r < 50) ltr = letter_t'($urandom_range(LAST_LETTER + 1, 31));
      else ltr = letter_t'($urandom_range(0, LAST_LETTER));
      fin = (i == len - 1);
      if (noisy && $urandom_range(0, 9) == 0) fin = ~fin;
      letter_queue.push_back('{ltr, fin});
      prev = ltr;
      count++;
    end
  endtask

  initial begin
    int random_done;
    int phase_items;
    int phase;
    int len;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset square is all zeros: only A is found, the rest fall to cell 0.
    letter_queue.push_back('{letter_t'(0), 1'b0});
    letter_queue.push_back('{letter_t'('1), 1'b1});
    drain_and_settle();

    load_setup(square_from("PLAYFIREXMBCDGHKNOQSTUVWZ"), 1'b0, '0);
    queue_char("P", 1'b0); queue_char("A", 1'b0);  // same row
    queue_char("L", 1'b0); queue_char("U", 1'b0);  // same column, wraps down
    queue_char("B", 1'b0); queue_char("Z", 1'b0);  // corners
    queue_char("E", 1'b0); queue_char("E", 1'b0);  // double, repeat is held
    queue_char("K", 1'b0);
    queue_char("O", 1'b0); queue_char("O", 1'b1);  // double at message end
    queue_char("F", 1'b1);                         // lone letter padded
    queue_char("J", 1'b0); queue_char("I", 1'b0);  // J folds into a double
    queue_char("Z", 1'b1);
    queue_char("X", 1'b0); queue_char("X", 1'b0);  // doubled filler letter
    queue_char("X", 1'b1);
    letter_queue.push_back('{letter_t'(LAST_LETTER + 3), 1'b0});  // off the square
    queue_char("C", 1'b1);
    queue_char("G", 1'b0);                         // left held across the mode change
    drain_and_settle();

    write_reg(CFG_DECRYPT_MODE, 50'd1);
    close_cfg();
    queue_char("G", 1'b0);                         // decrypt keeps the double
    queue_char("T", 1'b0); queue_char("W", 1'b1);

    random_done = 0;
    phase = 0;
    while (random_done < RANDOM_ITEMS) begin
      drain_and_settle();
      if (phase == 0) load_setup('1, 1'b1, '1);
      else if (phase == 1) load_setup('0, 1'b0, '0);
      else if ($urandom_range(0, 5) == 0)
        load_setup(corrupt_square(), 1'($urandom), 49'({$urandom, $urandom}));
      else
        load_setup(shuffled_square(), 1'($urandom), 49'({$urandom, $urandom}));
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
        queue_message(len, $urandom_range(0, 4) == 0, phase_items);
      end
      random_done += phase_items;
      phase++;
    end

    drain_and_settle();
    if (digraph_queue.size() != 0)
      report_mismatch($sformatf("%0d digraphs never arrived", digraph_queue.size()));

    $display("run: %0d letters over %0d key-square setups, %0d register writes",
             letters_in, setups, cfg_writes);
    $display("run: %0d digraphs checked, %0d letters split into two, %0d mismatches",
             digraphs_seen, double_hits, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pfc_pkg.sv
rtl/core/pfc_front.sv
rtl/core/pfc_queue.sv
rtl/core/pfc_back.sv
rtl/core/playfair_digraph_cipher_core.sv
dv/playfair_digraph_cipher_core_tb.sv
